>>> hdl/igdv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igdv_pkg
// Shared widths, constants and controller/datapath interface types for the
// inter-group delay variation block.
// ----------------------------------------------------------------------------
package igdv_pkg;

   localparam int TIME_BITS   = 40;
   localparam int COUNT_BITS  = 16;
   localparam int SUM_BITS    = TIME_BITS + COUNT_BITS;
   localparam int BYTES_BITS  = 16;
   localparam int TOTAL_BITS  = 32;
   localparam int ID_BITS     = 16;
   localparam int DIFF_BITS   = TIME_BITS + 1;
   localparam int VAR_BITS    = TIME_BITS + 2;
   localparam int DELTA_BITS  = TOTAL_BITS + 1;

   // low bits of each mean are all the differences need
   localparam int MEAN_BITS   = VAR_BITS;

   localparam int FRAME_BITS  = 10;
   localparam int CSR_DATA_BITS = 10;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CC_ENABLE      = 1'd1;

   localparam int NEW_GROUP_GAP_US   = 10000;
   localparam int WINDOW_FRAMES      = 6;
   localparam int US_PER_MS          = 1000;
   localparam int WINDOW_US_PER_MS   = WINDOW_FRAMES * US_PER_MS;
   localparam int FRAME_RESET        = 16;
   localparam int WIN_BITS           = $clog2(((1 << FRAME_BITS) - 1) * WINDOW_US_PER_MS + 1);

   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

   typedef struct packed {
      logic load;      // capture accepted beat
      logic seed;      // first record of the stream
      logic add;       // join current group
      logic close;     // rotate groups and start a new one with this record
      logic div_cur;   // start divider on current group sums
      logic div_pri;   // start divider on prior group sums
      logic cap_cur;   // capture current group means
      logic cap_pri;   // capture prior group means
      logic diff;      // form mean differences
      logic emit;      // load result register
   } igdv_cmd_type;

   typedef struct packed {
      logic cc_enable;
      logic first;
      logic accept;
      logic new_group;
      logic full;
      logic has_prior;
      logic div_done;
      logic rsp_full;
   } igdv_status_type;

endpackage

>>> hdl/igdv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igdv_div
// Two-lane restoring divider: two sums over one shared count, one quotient
// bit per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module igdv_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [igdv_pkg::SUM_BITS-1:0]       num_a,
   input  logic [igdv_pkg::SUM_BITS-1:0]       num_b,
   input  logic [igdv_pkg::COUNT_BITS-1:0]     den,
   output logic                                busy,
   output logic                                done,
   output logic [igdv_pkg::SUM_BITS-1:0]       quo_a,
   output logic [igdv_pkg::SUM_BITS-1:0]       quo_b
);

   localparam int SB = igdv_pkg::SUM_BITS;
   localparam int CB = igdv_pkg::COUNT_BITS;

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [igdv_pkg::DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SB-1:0]                      qa_ff, qa_in, qb_ff, qb_in;
   logic [CB-1:0]                      ra_ff, ra_in, rb_ff, rb_in;
   logic [CB-1:0]                      den_ff, den_in;
   logic [CB:0]                        sh_a, sh_b, sub_a, sub_b;
   logic                               ge_a, ge_b;

   always_comb begin
      sh_a  = {ra_ff, qa_ff[SB-1]};
      sh_b  = {rb_ff, qb_ff[SB-1]};
      sub_a = sh_a - {1'b0, den_ff};
      sub_b = sh_b - {1'b0, den_ff};
      ge_a  = (sh_a >= {1'b0, den_ff});
      ge_b  = (sh_b >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      den_in  = den_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = igdv_pkg::DIV_CNT_BITS'(SB - 1);
         qa_in   = num_a;
         qb_in   = num_b;
         ra_in   = '0;
         rb_in   = '0;
         den_in  = den;
      end else if (busy_ff) begin
         qa_in = {qa_ff[SB-2:0], ge_a};
         qb_in = {qb_ff[SB-2:0], ge_b};
         ra_in = ge_a ? sub_a[CB-1:0] : sh_a[CB-1:0];
         rb_in = ge_b ? sub_b[CB-1:0] : sh_b[CB-1:0];
         cnt_in = cnt_ff - igdv_pkg::DIV_CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qa_ff  <= qa_in;
      qb_ff  <= qb_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      den_ff <= den_in;
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign quo_a = (den_ff == '0) ? '0 : qa_ff;
   assign quo_b = (den_ff == '0) ? '0 : qb_ff;

endmodule

>>> hdl/igdv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igdv_ctrl
// Sequencer: classifies each record, runs the mean divisions when a group
// closes with a prior group on hand, and hands the result to the output.
// ----------------------------------------------------------------------------
module igdv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  igdv_pkg::igdv_status_type st,
   output igdv_pkg::igdv_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EVAL    = 3'd1;
   localparam logic [2:0] S_DIV_CUR = 3'd2;
   localparam logic [2:0] S_DIV_PRI = 3'd3;
   localparam logic [2:0] S_DIFF    = 3'd4;
   localparam logic [2:0] S_EMIT    = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (st.cc_enable) begin
               if (st.first) begin
                  cmd.seed = 1'b1;
               end else if (st.accept) begin
                  if (st.new_group) begin
                     if (st.has_prior) begin
                        cmd.div_cur = 1'b1;
                        state_in    = S_DIV_CUR;
                     end else begin
                        cmd.close = 1'b1;
                     end
                  end else if (!st.full) begin
                     cmd.add = 1'b1;
                  end
               end
            end
         end
         S_DIV_CUR: begin
            if (st.div_done) begin
               cmd.cap_cur = 1'b1;
               cmd.div_pri = 1'b1;
               state_in    = S_DIV_PRI;
            end
         end
         S_DIV_PRI: begin
            if (st.div_done) begin
               cmd.cap_pri = 1'b1;
               state_in    = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!st.rsp_full) begin
               cmd.emit  = 1'b1;
               cmd.close = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/igdv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igdv_datapath
// Group state, window check, config registers, mean divider and the result
// register with its handshake.
// ----------------------------------------------------------------------------
module igdv_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  igdv_pkg::igdv_cmd_type                   cmd,
   output igdv_pkg::igdv_status_type                st,
   input  logic                                     csr_valid,
   input  logic [igdv_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [igdv_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic [igdv_pkg::TIME_BITS-1:0]           req_now_us,
   input  logic [igdv_pkg::ID_BITS-1:0]             req_pkt_id,
   input  logic [igdv_pkg::TIME_BITS-1:0]           req_tx_time_us,
   input  logic [igdv_pkg::TIME_BITS-1:0]           req_rx_time_us,
   input  logic [igdv_pkg::BYTES_BITS-1:0]          req_pkt_bytes,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [igdv_pkg::TIME_BITS-1:0]           rsp_out_now_us,
   output logic [igdv_pkg::ID_BITS-1:0]             rsp_out_pkt_id,
   output logic [igdv_pkg::TIME_BITS-1:0]           rsp_out_rx_time_us,
   output logic signed [igdv_pkg::DIFF_BITS-1:0]    rsp_inter_arrival_us,
   output logic signed [igdv_pkg::DIFF_BITS-1:0]    rsp_inter_departure_us,
   output logic signed [igdv_pkg::VAR_BITS-1:0]     rsp_delay_variation_us,
   output logic signed [igdv_pkg::DELTA_BITS-1:0]   rsp_group_bytes_delta,
   output logic [igdv_pkg::TIME_BITS-1:0]           rsp_last_rx_time_us
);

   localparam int TB = igdv_pkg::TIME_BITS;
   localparam int CB = igdv_pkg::COUNT_BITS;
   localparam int SB = igdv_pkg::SUM_BITS;
   localparam int MB = igdv_pkg::MEAN_BITS;
   localparam int OB = igdv_pkg::TOTAL_BITS;
   localparam int WB = igdv_pkg::WIN_BITS;

   // config
   logic [WB-1:0]  window_ff;
   logic           cc_enable_ff;

   // latched beat
   logic [TB-1:0]                    now_ff, tx_ff, rx_ff;
   logic [igdv_pkg::ID_BITS-1:0]     id_ff;
   logic [igdv_pkg::BYTES_BITS-1:0]  bytes_ff;

   // group state
   logic           awaiting_ff, awaiting_in;
   logic           has_prior_ff, has_prior_in;
   logic [TB-1:0]  start_tx_ff, start_tx_in;
   logic [OB-1:0]  total_ff, total_in, prior_total_ff, prior_total_in;
   logic [TB-1:0]  last_rx_ff, last_rx_in;
   logic [SB-1:0]  cur_tx_ff, cur_tx_in, cur_rx_ff, cur_rx_in;
   logic [SB-1:0]  pri_tx_ff, pri_tx_in, pri_rx_ff, pri_rx_in;
   logic [CB-1:0]  cur_cnt_ff, cur_cnt_in, pri_cnt_ff, pri_cnt_in;

   // means and differences
   logic [MB-1:0]  mc_tx_ff, mc_rx_ff, mp_tx_ff, mp_rx_ff;
   logic [MB-1:0]  arr_ff, dep_ff;

   logic           rsp_valid_ff;

   // window check
   logic [TB-1:0]  tx_gap;
   logic           tx_eq, tx_gt;

   // divider
   logic [SB-1:0]  div_num_a, div_num_b, quo_a, quo_b;
   logic [CB-1:0]  div_den;
   logic           div_busy, div_done;

   always_comb begin
      tx_gap = tx_ff - start_tx_ff;
      tx_eq  = (tx_ff == start_tx_ff);
      tx_gt  = (tx_ff > start_tx_ff);

      st.cc_enable = cc_enable_ff;
      st.first     = awaiting_ff;
      st.accept    = tx_eq || (tx_gt && (tx_gap < TB'(window_ff)));
      st.new_group = (tx_gap > TB'(igdv_pkg::NEW_GROUP_GAP_US));
      st.full      = (cur_cnt_ff == {CB{1'b1}});
      st.has_prior = has_prior_ff;
      st.div_done  = div_done;
      st.rsp_full  = rsp_valid_ff;
   end

   assign div_num_a = cmd.div_pri ? pri_tx_ff : cur_tx_ff;
   assign div_num_b = cmd.div_pri ? pri_rx_ff : cur_rx_ff;
   assign div_den   = cmd.div_pri ? pri_cnt_ff : cur_cnt_ff;

   igdv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_cur || cmd.div_pri),
      .num_a (div_num_a),
      .num_b (div_num_b),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo_a (quo_a),
      .quo_b (quo_b)
   );

   // group state update
   always_comb begin
      awaiting_in    = awaiting_ff;
      has_prior_in   = has_prior_ff;
      start_tx_in    = start_tx_ff;
      total_in       = total_ff;
      prior_total_in = prior_total_ff;
      last_rx_in     = last_rx_ff;
      cur_tx_in      = cur_tx_ff;
      cur_rx_in      = cur_rx_ff;
      cur_cnt_in     = cur_cnt_ff;
      pri_tx_in      = pri_tx_ff;
      pri_rx_in      = pri_rx_ff;
      pri_cnt_in     = pri_cnt_ff;
      if (cmd.seed) begin
         // first record sets the group but leaves the time sums alone
         awaiting_in  = 1'b0;
         has_prior_in = 1'b0;
         start_tx_in  = tx_ff;
         total_in     = OB'(bytes_ff);
         last_rx_in   = rx_ff;
         cur_cnt_in   = CB'(1);
      end else if (cmd.close) begin
         has_prior_in   = 1'b1;
         prior_total_in = total_ff;
         pri_tx_in      = cur_tx_ff;
         pri_rx_in      = cur_rx_ff;
         pri_cnt_in     = cur_cnt_ff;
         start_tx_in    = tx_ff;
         total_in       = OB'(bytes_ff);
         cur_tx_in      = SB'(tx_ff);
         cur_rx_in      = SB'(rx_ff);
         cur_cnt_in     = CB'(1);
         last_rx_in     = rx_ff;
      end else if (cmd.add) begin
         total_in   = total_ff + OB'(bytes_ff);
         cur_tx_in  = cur_tx_ff + SB'(tx_ff);
         cur_rx_in  = cur_rx_ff + SB'(rx_ff);
         cur_cnt_in = cur_cnt_ff + CB'(1);
         last_rx_in = rx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= WB'(igdv_pkg::FRAME_RESET * igdv_pkg::WINDOW_US_PER_MS);
         cc_enable_ff   <= 1'b0;
         awaiting_ff    <= 1'b1;
         has_prior_ff   <= 1'b0;
         start_tx_ff    <= '0;
         total_ff       <= '0;
         prior_total_ff <= '0;
         last_rx_ff     <= '0;
         cur_tx_ff      <= '0;
         cur_rx_ff      <= '0;
         cur_cnt_ff     <= '0;
         pri_tx_ff      <= '0;
         pri_rx_ff      <= '0;
         pri_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               igdv_pkg::CSR_FRAME_INTERVAL: begin
                  window_ff <= WB'(csr_wdata[igdv_pkg::FRAME_BITS-1:0])
                               * WB'(igdv_pkg::WINDOW_US_PER_MS);
               end
               igdv_pkg::CSR_CC_ENABLE: begin
                  cc_enable_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         awaiting_ff    <= awaiting_in;
         has_prior_ff   <= has_prior_in;
         start_tx_ff    <= start_tx_in;
         total_ff       <= total_in;
         prior_total_ff <= prior_total_in;
         last_rx_ff     <= last_rx_in;
         cur_tx_ff      <= cur_tx_in;
         cur_rx_ff      <= cur_rx_in;
         cur_cnt_ff     <= cur_cnt_in;
         pri_tx_ff      <= pri_tx_in;
         pri_rx_ff      <= pri_rx_in;
         pri_cnt_ff     <= pri_cnt_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff   <= req_now_us;
         id_ff    <= req_pkt_id;
         tx_ff    <= req_tx_time_us;
         rx_ff    <= req_rx_time_us;
         bytes_ff <= req_pkt_bytes;
      end
      if (cmd.cap_cur) begin
         mc_tx_ff <= quo_a[MB-1:0];
         mc_rx_ff <= quo_b[MB-1:0];
      end
      if (cmd.cap_pri) begin
         mp_tx_ff <= quo_a[MB-1:0];
         mp_rx_ff <= quo_b[MB-1:0];
      end
      if (cmd.diff) begin
         arr_ff <= mc_rx_ff - mp_rx_ff;
         dep_ff <= mc_tx_ff - mp_tx_ff;
      end
      if (cmd.emit) begin
         rsp_out_now_us         <= now_ff;
         rsp_out_pkt_id         <= id_ff;
         rsp_out_rx_time_us     <= rx_ff;
         rsp_inter_arrival_us   <= arr_ff[igdv_pkg::DIFF_BITS-1:0];
         rsp_inter_departure_us <= dep_ff[igdv_pkg::DIFF_BITS-1:0];
         rsp_delay_variation_us <= arr_ff - dep_ff;
         rsp_group_bytes_delta  <= {1'b0, total_ff} - {1'b0, prior_total_ff};
         rsp_last_rx_time_us    <= last_rx_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      !awaiting_ff |-> (cur_cnt_ff != '0))
      else $error("current group count is zero after seeding");

   a_prior_count: assert property (@(posedge clock) disable iff (reset)
      has_prior_ff |-> (pri_cnt_ff != '0))
      else $error("prior group marked present with zero count");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_valid_ff)
      else $error("result register overwritten while full");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_cur || cmd.div_pri) |-> !div_busy)
      else $error("divider started while busy");

   a_seed_once: assert property (@(posedge clock) disable iff (reset)
      cmd.seed |=> !awaiting_ff && !has_prior_ff)
      else $error("seed did not clear first-record state");

endmodule

>>> hdl/inter_group_delay_variation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inter_group_delay_variation_top
// Groups feedback records into send-time bursts and reports mean delay
// variation and byte delta between consecutive groups.
// ----------------------------------------------------------------------------
// Sequencing: a record that closes no group passes the load and evaluate
//   states only; one closing a group with a prior group present then runs
//   two passes of the bit-serial mean divider, forms the differences and sets
//   rsp_valid from the emit state, which waits while the result is unread.
//   A new record is taken only once the last one is done.
// Reset: synchronous; clears group state, restores frame interval 16 ms
//   and disables processing.
module inter_group_delay_variation_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [igdv_pkg::TIME_BITS-1:0]           req_now_us,
   input  logic [igdv_pkg::ID_BITS-1:0]             req_pkt_id,
   input  logic [igdv_pkg::TIME_BITS-1:0]           req_tx_time_us,
   input  logic [igdv_pkg::TIME_BITS-1:0]           req_rx_time_us,
   input  logic [igdv_pkg::BYTES_BITS-1:0]          req_pkt_bytes,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [igdv_pkg::TIME_BITS-1:0]           rsp_out_now_us,
   output logic [igdv_pkg::ID_BITS-1:0]             rsp_out_pkt_id,
   output logic [igdv_pkg::TIME_BITS-1:0]           rsp_out_rx_time_us,
   output logic signed [igdv_pkg::DIFF_BITS-1:0]    rsp_inter_arrival_us,
   output logic signed [igdv_pkg::DIFF_BITS-1:0]    rsp_inter_departure_us,
   output logic signed [igdv_pkg::VAR_BITS-1:0]     rsp_delay_variation_us,
   output logic signed [igdv_pkg::DELTA_BITS-1:0]   rsp_group_bytes_delta,
   output logic [igdv_pkg::TIME_BITS-1:0]           rsp_last_rx_time_us,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [igdv_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [igdv_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   igdv_pkg::igdv_cmd_type    cmd;
   igdv_pkg::igdv_status_type st;

   assign csr_ready = 1'b1;

   igdv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   igdv_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .st                     (st),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_now_us             (req_now_us),
      .req_pkt_id             (req_pkt_id),
      .req_tx_time_us         (req_tx_time_us),
      .req_rx_time_us         (req_rx_time_us),
      .req_pkt_bytes          (req_pkt_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_now_us         (rsp_out_now_us),
      .rsp_out_pkt_id         (rsp_out_pkt_id),
      .rsp_out_rx_time_us     (rsp_out_rx_time_us),
      .rsp_inter_arrival_us   (rsp_inter_arrival_us),
      .rsp_inter_departure_us (rsp_inter_departure_us),
      .rsp_delay_variation_us (rsp_delay_variation_us),
      .rsp_group_bytes_delta  (rsp_group_bytes_delta),
      .rsp_last_rx_time_us    (rsp_last_rx_time_us)
   );

endmodule
